// ===== sv/flr_pkg.sv =====
`timescale 1ns / 1ps

package flr_pkg;

   localparam int COL_W    = 8;
   localparam int ROW_W    = 7;
   localparam int WIDTH_W  = 9;
   localparam int HEIGHT_W = 8;
   localparam int COORD_W  = 10;
   localparam int LUM_W    = 8;
   localparam int ERR_W    = 10;
   localparam int MODE_W   = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;

   localparam logic [MODE_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [MODE_W-1:0] OP_POINT = 2'd1;
   localparam logic [MODE_W-1:0] OP_LINE  = 2'd2;
   localparam logic [MODE_W-1:0] OP_READ  = 2'd3;

   localparam logic STATUS_DONE   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_CANVAS_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CANVAS_HEIGHT = 1'd1;

   localparam logic [WIDTH_W-1:0]  CANVAS_WIDTH_RESET  = 9'd80;
   localparam logic [HEIGHT_W-1:0] CANVAS_HEIGHT_RESET = 8'd24;

   localparam logic [LUM_W-1:0] CLEAR_LOWER_LUM = 8'd15;
   localparam logic [LUM_W-1:0] CLEAR_UPPER_LUM = 8'd0;

   localparam int QUEUE_DEPTH = 2;

   // A classified command as it travels from the front end to the drawing engine.
   typedef struct packed {
      logic [MODE_W-1:0]       op;
      logic                    reject;
      logic [COL_W-1:0]        x0;
      logic [ROW_W-1:0]        y0;
      logic [COL_W-1:0]        x1;
      logic [ROW_W-1:0]        y1;
      logic [COL_W-1:0]        dx;
      logic [ROW_W-1:0]        dy;
      logic                    step_x_neg;
      logic                    step_y_neg;
      logic signed [ERR_W-1:0] err0;
      logic [LUM_W-1:0]        lum;
      logic [WIDTH_W-1:0]      width;
      logic [HEIGHT_W-1:0]     height;
   } cmd_type;

endpackage

// ===== sv/flr_front.sv =====
`timescale 1ns / 1ps

module flr_front #(
   parameter int MAX_COLUMNS = 256,
   parameter int MAX_ROWS    = 128
) (
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [flr_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [flr_pkg::COORD_W-1:0]   req_start_x,
   input  logic signed [flr_pkg::COORD_W-1:0]   req_start_y,
   input  logic signed [flr_pkg::COORD_W-1:0]   req_end_x,
   input  logic signed [flr_pkg::COORD_W-1:0]   req_end_y,
   input  logic [flr_pkg::LUM_W-1:0]            req_brightness,
   input  logic [flr_pkg::WIDTH_W-1:0]          canvas_width,
   input  logic [flr_pkg::HEIGHT_W-1:0]         canvas_height,
   input  logic                                 queue_full,
   output logic                                 push,
   output flr_pkg::cmd_type                     cmd
);

   localparam logic [flr_pkg::WIDTH_W-1:0]  COL_LIMIT = flr_pkg::WIDTH_W'(MAX_COLUMNS);
   localparam logic [flr_pkg::HEIGHT_W-1:0] ROW_LIMIT = flr_pkg::HEIGHT_W'(MAX_ROWS);

   logic [flr_pkg::WIDTH_W-1:0]  eff_width;
   logic [flr_pkg::HEIGHT_W-1:0] eff_height;
   logic                         start_on;
   logic                         end_on;
   logic [flr_pkg::COL_W-1:0]    x0;
   logic [flr_pkg::COL_W-1:0]    x1;
   logic [flr_pkg::ROW_W-1:0]    y0;
   logic [flr_pkg::ROW_W-1:0]    y1;
   logic [flr_pkg::COL_W-1:0]    dx;
   logic [flr_pkg::ROW_W-1:0]    dy;
   logic [flr_pkg::ERR_W-1:0]    half_dx;
   logic [flr_pkg::ERR_W-1:0]    half_dy;

   function automatic logic on_canvas(
      input logic signed [flr_pkg::COORD_W-1:0] x,
      input logic signed [flr_pkg::COORD_W-1:0] y,
      input logic [flr_pkg::WIDTH_W-1:0]        w,
      input logic [flr_pkg::HEIGHT_W-1:0]       h
   );
      return !x[flr_pkg::COORD_W-1] && !y[flr_pkg::COORD_W-1] &&
             (x[flr_pkg::COORD_W-2:0] < w) &&
             (y[flr_pkg::COORD_W-2:0] < {1'b0, h});
   endfunction

   always_comb begin
      eff_width  = (canvas_width > COL_LIMIT) ? COL_LIMIT : canvas_width;
      eff_height = (canvas_height > ROW_LIMIT) ? ROW_LIMIT : canvas_height;
      start_on   = on_canvas(req_start_x, req_start_y, eff_width, eff_height);
      end_on     = on_canvas(req_end_x, req_end_y, eff_width, eff_height);

      // Once a point is known to be on the canvas its coordinates fit these widths.
      x0 = req_start_x[flr_pkg::COL_W-1:0];
      y0 = req_start_y[flr_pkg::ROW_W-1:0];
      x1 = req_end_x[flr_pkg::COL_W-1:0];
      y1 = req_end_y[flr_pkg::ROW_W-1:0];
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      half_dx = {3'b000, dx[flr_pkg::COL_W-1:1]};
      half_dy = {4'b0000, dy[flr_pkg::ROW_W-1:1]};

      cmd.op         = req_mode;
      cmd.x0         = x0;
      cmd.y0         = y0;
      cmd.x1         = x1;
      cmd.y1         = y1;
      cmd.dx         = dx;
      cmd.dy         = dy;
      cmd.step_x_neg = !(x0 < x1);
      cmd.step_y_neg = !(y0 < y1);
      // The error starts at half the major delta, negative when rows lead.
      cmd.err0       = (dx > {1'b0, dy}) ? half_dx : (~half_dy + 10'd1);
      cmd.lum        = req_brightness;
      cmd.width      = eff_width;
      cmd.height     = eff_height;

      unique case (req_mode)
         flr_pkg::OP_CLEAR: cmd.reject = 1'b0;
         flr_pkg::OP_POINT: cmd.reject = !start_on;
         flr_pkg::OP_LINE:  cmd.reject = !(start_on && end_on);
         flr_pkg::OP_READ:  cmd.reject = !start_on;
         default:           cmd.reject = 1'b0;
      endcase

      req_ready = !queue_full;
      push      = req_valid && !queue_full;
   end

endmodule

// ===== sv/flr_queue.sv =====
`timescale 1ns / 1ps

module flr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  flr_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output flr_pkg::cmd_type head
);

   localparam int PTR_W = (flr_pkg::QUEUE_DEPTH > 1) ? $clog2(flr_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(flr_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(flr_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(flr_pkg::QUEUE_DEPTH);

   flr_pkg::cmd_type     entry_ff [flr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;

   always_comb begin
      full      = (count_ff == FULL_CNT);
      not_empty = (count_ff != '0);
      head      = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/flr_engine.sv =====
`timescale 1ns / 1ps

module flr_engine #(
   parameter int MAX_COLUMNS = 256,
   parameter int MAX_ROWS    = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   input  flr_pkg::cmd_type               cmd,
   output logic                           cmd_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_status,
   output logic [flr_pkg::LUM_W-1:0]      rsp_pixel_value
);

   localparam int CW        = $clog2(MAX_COLUMNS);
   localparam int RW        = $clog2(MAX_ROWS);
   localparam int ADDR_W    = CW + RW;
   localparam int MEM_DEPTH = 1 << ADDR_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_LINE  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [flr_pkg::LUM_W-1:0] pixel_mem [MEM_DEPTH];

   logic [2:0]                     state_ff,    state_in;
   logic [flr_pkg::COL_W-1:0]      col_ff,      col_in;
   logic [flr_pkg::ROW_W-1:0]      row_ff,      row_in;
   logic [flr_pkg::COL_W-1:0]      end_col_ff,  end_col_in;
   logic [flr_pkg::ROW_W-1:0]      end_row_ff,  end_row_in;
   logic [flr_pkg::COL_W-1:0]      dx_ff,       dx_in;
   logic [flr_pkg::ROW_W-1:0]      dy_ff,       dy_in;
   logic                           sxn_ff,      sxn_in;
   logic                           syn_ff,      syn_in;
   logic signed [flr_pkg::ERR_W-1:0] err_ff,    err_in;
   logic [flr_pkg::LUM_W-1:0]      lum_ff,      lum_in;
   logic [flr_pkg::ROW_W-1:0]      half_row_ff, half_row_in;
   logic                           status_ff,   status_in;
   logic                           is_read_ff,  is_read_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_status_ff, rsp_status_in;
   logic [flr_pkg::LUM_W-1:0]      rsp_pixel_ff, rsp_pixel_in;
   logic [flr_pkg::LUM_W-1:0]      rd_data_ff;

   logic                           mem_we;
   logic [ADDR_W-1:0]              mem_waddr;
   logic [flr_pkg::LUM_W-1:0]      mem_wdata;
   logic                           mem_re;
   logic [ADDR_W-1:0]              mem_raddr;

   logic signed [flr_pkg::ERR_W-1:0] dx_s;
   logic signed [flr_pkg::ERR_W-1:0] dy_s;
   logic                           x_move;
   logic                           y_move;

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      end_col_in    = end_col_ff;
      end_row_in    = end_row_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sxn_in        = sxn_ff;
      syn_in        = syn_ff;
      err_in        = err_ff;
      lum_in        = lum_ff;
      half_row_in   = half_row_ff;
      status_in     = status_ff;
      is_read_in    = is_read_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pixel_in  = rsp_pixel_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = {row_ff[RW-1:0], col_ff[CW-1:0]};
      mem_wdata     = lum_ff;
      mem_re        = 1'b0;
      mem_raddr     = {cmd.y0[RW-1:0], cmd.x0[CW-1:0]};

      dx_s   = $signed({2'b00, dx_ff});
      dy_s   = $signed({3'b000, dy_ff});
      x_move = err_ff > -dx_s;
      y_move = err_ff < dy_s;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               status_in  = flr_pkg::STATUS_DONE;
               is_read_in = 1'b0;
               state_in   = ST_DONE;
               if (cmd.reject) begin
                  status_in = flr_pkg::STATUS_REJECT;
               end else begin
                  unique case (cmd.op)
                     flr_pkg::OP_CLEAR: begin
                        col_in      = '0;
                        row_in      = '0;
                        // End positions hold the last column and row of the sweep.
                        end_col_in  = flr_pkg::COL_W'(cmd.width - 9'd1);
                        end_row_in  = flr_pkg::ROW_W'(cmd.height - 8'd1);
                        half_row_in = flr_pkg::ROW_W'(cmd.height >> 1);
                        if (cmd.width != '0 && cmd.height != '0) begin
                           state_in = ST_CLEAR;
                        end
                     end
                     flr_pkg::OP_POINT: begin
                        mem_we    = 1'b1;
                        mem_waddr = {cmd.y0[RW-1:0], cmd.x0[CW-1:0]};
                        mem_wdata = cmd.lum;
                     end
                     flr_pkg::OP_LINE: begin
                        col_in     = cmd.x0;
                        row_in     = cmd.y0;
                        end_col_in = cmd.x1;
                        end_row_in = cmd.y1;
                        dx_in      = cmd.dx;
                        dy_in      = cmd.dy;
                        sxn_in     = cmd.step_x_neg;
                        syn_in     = cmd.step_y_neg;
                        err_in     = cmd.err0;
                        lum_in     = cmd.lum;
                        state_in   = ST_LINE;
                     end
                     flr_pkg::OP_READ: begin
                        mem_re     = 1'b1;
                        is_read_in = 1'b1;
                        state_in   = ST_READ;
                     end
                     default: state_in = ST_DONE;
                  endcase
               end
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = (row_ff >= half_row_ff) ? flr_pkg::CLEAR_LOWER_LUM
                                                : flr_pkg::CLEAR_UPPER_LUM;
            if (col_ff == end_col_ff) begin
               col_in = '0;
               if (row_ff == end_row_ff) begin
                  state_in = ST_DONE;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_LINE: begin
            mem_we = 1'b1;
            if (col_ff == end_col_ff && row_ff == end_row_ff) begin
               state_in = ST_DONE;
            end else begin
               // Both tests use the error as it stood before this step.
               err_in = err_ff - (x_move ? dy_s : '0) + (y_move ? dx_s : '0);
               if (x_move) begin
                  col_in = sxn_ff ? col_ff - 1'b1 : col_ff + 1'b1;
               end
               if (y_move) begin
                  row_in = syn_ff ? row_ff - 1'b1 : row_ff + 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pixel_in  = is_read_ff ? rd_data_ff : '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         err_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         err_ff       <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      end_col_ff    <= end_col_in;
      end_row_ff    <= end_row_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      sxn_ff        <= sxn_in;
      syn_ff        <= syn_in;
      lum_ff        <= lum_in;
      half_row_ff   <= half_row_in;
      status_ff     <= status_in;
      is_read_ff    <= is_read_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pixel_ff  <= rsp_pixel_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= pixel_mem[mem_raddr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pixel_value = rsp_pixel_ff;

endmodule

// ===== sv/framebuffer_line_rasterizer_unit.sv =====
// A point or rejected command goes from the idle state to the done state; a read passes the read state on the way.
// A line is drawn by the walker in the line state: the walker writes one pixel per cycle.
// A clear sweeps the canvas: the sweep writes one pixel per cycle.
// Throughput is one command at a time in the engine; a two-entry queue takes more items.
// Reset clears control state and sets the canvas to 80 by 24; pixel memory is not cleared.
`timescale 1ns / 1ps

module framebuffer_line_rasterizer_unit #(
   parameter int MAX_COLUMNS = 256,
   parameter int MAX_ROWS    = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [flr_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [flr_pkg::COORD_W-1:0]   req_start_x,
   input  logic signed [flr_pkg::COORD_W-1:0]   req_start_y,
   input  logic signed [flr_pkg::COORD_W-1:0]   req_end_x,
   input  logic signed [flr_pkg::COORD_W-1:0]   req_end_y,
   input  logic [flr_pkg::LUM_W-1:0]            req_brightness,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_status,
   output logic [flr_pkg::LUM_W-1:0]            rsp_pixel_value,
   input  logic                                 csr_write_enable,
   input  logic [flr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [flr_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   logic [flr_pkg::WIDTH_W-1:0]  canvas_width_ff;
   logic [flr_pkg::WIDTH_W-1:0]  canvas_width_in;
   logic [flr_pkg::HEIGHT_W-1:0] canvas_height_ff;
   logic [flr_pkg::HEIGHT_W-1:0] canvas_height_in;

   logic             queue_full;
   logic             push;
   flr_pkg::cmd_type push_cmd;
   logic             queue_not_empty;
   logic             pop;
   flr_pkg::cmd_type head_cmd;

   always_comb begin
      canvas_width_in  = canvas_width_ff;
      canvas_height_in = canvas_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            flr_pkg::REG_CANVAS_WIDTH:  canvas_width_in  = csr_write_data;
            flr_pkg::REG_CANVAS_HEIGHT: canvas_height_in =
               csr_write_data[flr_pkg::HEIGHT_W-1:0];
            default: canvas_width_in = canvas_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= flr_pkg::CANVAS_WIDTH_RESET;
         canvas_height_ff <= flr_pkg::CANVAS_HEIGHT_RESET;
      end else begin
         canvas_width_ff  <= canvas_width_in;
         canvas_height_ff <= canvas_height_in;
      end
   end

   flr_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_brightness (req_brightness),
      .canvas_width   (canvas_width_ff),
      .canvas_height  (canvas_height_ff),
      .queue_full     (queue_full),
      .push           (push),
      .cmd            (push_cmd)
   );

   flr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .head      (head_cmd)
   );

   flr_engine #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (queue_not_empty),
      .cmd             (head_cmd),
      .cmd_pop         (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_pixel_value (rsp_pixel_value)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int FRAME_COLS     = 256;
   localparam int FRAME_ROWS     = 128;
   localparam int FRAME_PIXELS   = FRAME_COLS * FRAME_ROWS;
   // A full-size clear sweeps 32768 pixels with nothing accepted on either side,
   // and a long receiver hold can follow it, so the limit sits well above that.
   localparam int WATCHDOG_LIMIT = 200000;

   typedef struct {
      logic [flr_pkg::MODE_W-1:0]         mode;
      logic signed [flr_pkg::COORD_W-1:0] sx;
      logic signed [flr_pkg::COORD_W-1:0] sy;
      logic signed [flr_pkg::COORD_W-1:0] ex;
      logic signed [flr_pkg::COORD_W-1:0] ey;
      logic [flr_pkg::LUM_W-1:0]          lum;
   } command_type;

   typedef struct {
      logic                      status;
      logic [flr_pkg::LUM_W-1:0] pixel;
   } response_type;

   logic                               clock            = 1'b0;
   logic                               reset            = 1'b1;
   logic                               req_valid        = 1'b0;
   logic                               req_ready;
   logic [flr_pkg::MODE_W-1:0]         req_mode         = flr_pkg::OP_CLEAR;
   logic signed [flr_pkg::COORD_W-1:0] req_start_x      = '0;
   logic signed [flr_pkg::COORD_W-1:0] req_start_y      = '0;
   logic signed [flr_pkg::COORD_W-1:0] req_end_x        = '0;
   logic signed [flr_pkg::COORD_W-1:0] req_end_y        = '0;
   logic [flr_pkg::LUM_W-1:0]          req_brightness   = '0;
   logic                               rsp_valid;
   logic                               rsp_ready        = 1'b0;
   logic                               rsp_status;
   logic [flr_pkg::LUM_W-1:0]          rsp_pixel_value;
   logic                               csr_write_enable = 1'b0;
   logic [flr_pkg::CSR_INDEX_W-1:0]    csr_index        = flr_pkg::REG_CANVAS_WIDTH;
   logic [flr_pkg::CSR_DATA_W-1:0]     csr_write_data   = '0;

   // Shadow of the frame buffer and the canvas registers.
   logic [flr_pkg::LUM_W-1:0]    shadow_pixels [FRAME_PIXELS];
   bit                           pixel_written [FRAME_PIXELS];
   logic [flr_pkg::WIDTH_W-1:0]  shadow_width  = flr_pkg::CANVAS_WIDTH_RESET;
   logic [flr_pkg::HEIGHT_W-1:0] shadow_height = flr_pkg::CANVAS_HEIGHT_RESET;

   response_type predicted_responses [$];

   int  mismatch_count    = 0;
   int  responses_checked = 0;
   int  canvas_settings   = 1;
   int  op_count [4]      = '{0, 0, 0, 0};
   int  stalled_cycles    = 0;
   int  stall_left        = 0;
   int  long_hold_cycles  = 0;
   bit  idling_enabled    = 1'b1;

   always #5 clock = ~clock;

   framebuffer_line_rasterizer_unit #(
      .MAX_COLUMNS(FRAME_COLS),
      .MAX_ROWS   (FRAME_ROWS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_brightness  (req_brightness),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_pixel_value (rsp_pixel_value),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   // ---------------------------------------------------------------- predictor

   function automatic int canvas_cols();
      return (shadow_width > FRAME_COLS) ? FRAME_COLS : int'(shadow_width);
   endfunction

   function automatic int canvas_rows();
      return (shadow_height > FRAME_ROWS) ? FRAME_ROWS : int'(shadow_height);
   endfunction

   function automatic bit on_canvas(input int x, input int y);
      return x >= 0 && y >= 0 && x < canvas_cols() && y < canvas_rows();
   endfunction

   function automatic int pixel_addr(input int x, input int y);
      return y * FRAME_COLS + x;
   endfunction

   function automatic void store_pixel(input int x, input int y,
                                       input logic [flr_pkg::LUM_W-1:0] lum);
      shadow_pixels[pixel_addr(x, y)] = lum;
      pixel_written[pixel_addr(x, y)] = 1'b1;
   endfunction

   function automatic response_type rasterize_command(input command_type c);
      response_type r;
      int x0, y0, x1, y1, dx, dy, step_x, step_y, err, e2, cols, rows;
      r.status = flr_pkg::STATUS_DONE;
      r.pixel  = '0;
      x0 = int'(c.sx);
      y0 = int'(c.sy);
      x1 = int'(c.ex);
      y1 = int'(c.ey);
      cols = canvas_cols();
      rows = canvas_rows();
      case (c.mode)
         flr_pkg::OP_CLEAR: begin
            for (int row = 0; row < rows; row++)
               for (int col = 0; col < cols; col++)
                  store_pixel(col, row, (row >= rows / 2) ? flr_pkg::CLEAR_LOWER_LUM
                                                          : flr_pkg::CLEAR_UPPER_LUM);
         end
         flr_pkg::OP_POINT: begin
            if (on_canvas(x0, y0)) store_pixel(x0, y0, c.lum);
            else r.status = flr_pkg::STATUS_REJECT;
         end
         flr_pkg::OP_LINE: begin
            if (on_canvas(x0, y0) && on_canvas(x1, y1)) begin
               dx     = (x1 > x0) ? x1 - x0 : x0 - x1;
               dy     = (y1 > y0) ? y1 - y0 : y0 - y1;
               step_x = (x0 < x1) ? 1 : -1;
               step_y = (y0 < y1) ? 1 : -1;
               err    = (dx > dy) ? dx / 2 : -(dy / 2);
               forever begin
                  store_pixel(x0, y0, c.lum);
                  if (x0 == x1 && y0 == y1) break;
                  e2 = err;
                  if (e2 > -dx) begin
                     err -= dy;
                     x0  += step_x;
                  end
                  if (e2 < dy) begin
                     err += dx;
                     y0  += step_y;
                  end
               end
            end else begin
               r.status = flr_pkg::STATUS_REJECT;
            end
         end
         default: begin
            if (on_canvas(x0, y0)) r.pixel = shadow_pixels[pixel_addr(x0, y0)];
            else r.status = flr_pkg::STATUS_REJECT;
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic command_type make_command(input logic [flr_pkg::MODE_W-1:0] mode,
                                                input int sx, input int sy, input int ex,
                                                input int ey, input int lum);
      command_type c;
      c.mode = mode;
      c.sx   = flr_pkg::COORD_W'(sx);
      c.sy   = flr_pkg::COORD_W'(sy);
      c.ex   = flr_pkg::COORD_W'(ex);
      c.ey   = flr_pkg::COORD_W'(ey);
      c.lum  = flr_pkg::LUM_W'(lum);
      return c;
   endfunction

   // Mostly on the canvas, with a share just past either edge and a share anywhere.
   function automatic logic signed [flr_pkg::COORD_W-1:0] pick_coord(input int extent);
      int roll;
      roll = $urandom_range(0, 99);
      if (extent > 0 && roll < 82)
         return flr_pkg::COORD_W'($urandom_range(0, extent - 1));
      else if (roll < 90) return flr_pkg::COORD_W'($urandom);
      else if (roll < 95) return flr_pkg::COORD_W'(extent + int'($urandom_range(0, 3)));
      else return flr_pkg::COORD_W'(-1 - int'($urandom_range(0, 3)));
   endfunction

   function automatic command_type random_command(input int clear_pct);
      command_type c;
      int roll;
      roll   = $urandom_range(0, 99);
      c.sx   = pick_coord(canvas_cols());
      c.sy   = pick_coord(canvas_rows());
      c.ex   = pick_coord(canvas_cols());
      c.ey   = pick_coord(canvas_rows());
      c.lum  = flr_pkg::LUM_W'($urandom_range(0, 255));
      if (roll < clear_pct) c.mode = flr_pkg::OP_CLEAR;
      else if (roll < clear_pct + 30) c.mode = flr_pkg::OP_POINT;
      else if (roll < clear_pct + 70) c.mode = flr_pkg::OP_LINE;
      else c.mode = flr_pkg::OP_READ;
      return c;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (!idling_enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      else if (roll < 93) return $urandom_range(1, 3);
      else return $urandom_range(10, 40);
   endfunction

   // Valid stays high after acceptance when no gap follows, so that a back-to-back
   // item never sees valid lowered and raised in the same step.
   task automatic send_command(input command_type c);
      int gap;
      req_valid      <= 1'b1;
      req_mode       <= c.mode;
      req_start_x    <= c.sx;
      req_start_y    <= c.sy;
      req_end_x      <= c.ex;
      req_end_y      <= c.ey;
      req_brightness <= c.lum;
      do @(posedge clock); while (!req_ready);
      op_count[c.mode]++;
      predicted_responses.push_back(rasterize_command(c));
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // A read of a pixel on the canvas that was never written is preceded by a point to that pixel.
   task automatic send_safe_command(input command_type c);
      command_type seed;
      if (c.mode == flr_pkg::OP_READ && on_canvas(int'(c.sx), int'(c.sy)) &&
          !pixel_written[pixel_addr(int'(c.sx), int'(c.sy))]) begin
         seed      = c;
         seed.mode = flr_pkg::OP_POINT;
         send_command(seed);
      end
      send_command(c);
   endtask

   task automatic wait_results_done();
      if (req_valid) req_valid <= 1'b0;
      while (predicted_responses.size() != 0) @(posedge clock);
   endtask

   task automatic set_canvas(input int cols, input int rows);
      wait_results_done();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= flr_pkg::REG_CANVAS_WIDTH;
      csr_write_data   <= flr_pkg::CSR_DATA_W'(cols);
      @(posedge clock);
      shadow_width     = flr_pkg::WIDTH_W'(cols);
      csr_index        <= flr_pkg::REG_CANVAS_HEIGHT;
      csr_write_data   <= flr_pkg::CSR_DATA_W'(rows & 8'hFF);
      @(posedge clock);
      shadow_height    = flr_pkg::HEIGHT_W'(rows);
      csr_write_enable <= 1'b0;
      canvas_settings++;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $realtime, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_responses.size() == 0) begin
               report_mismatch("response item arrived with nothing outstanding");
            end else begin
               response_type exp_rsp;
               exp_rsp = predicted_responses.pop_front();
               responses_checked++;
               if (rsp_status !== exp_rsp.status)
                  report_mismatch($sformatf("status %0b, expected %0b",
                                            rsp_status, exp_rsp.status));
               if (rsp_pixel_value !== exp_rsp.pixel)
                  report_mismatch($sformatf("pixel_value %0d, expected %0d",
                                            rsp_pixel_value, exp_rsp.pixel));
            end
         end
         if (long_hold_cycles > 0) begin
            long_hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling_enabled && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // Runs on the canvas left by reset, which the first clear fills.
   task automatic test_default_canvas();
      send_command(make_command(flr_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
      send_command(make_command(flr_pkg::OP_READ, 0, 0, 0, 0, 0));
      send_command(make_command(flr_pkg::OP_READ, 79, 23, 0, 0, 0));
      send_command(make_command(flr_pkg::OP_POINT, 5, 3, 0, 0, 255));
      send_command(make_command(flr_pkg::OP_READ, 5, 3, 0, 0, 0));
      send_command(make_command(flr_pkg::OP_POINT, -1, 0, 0, 0, 7));
      send_command(make_command(flr_pkg::OP_POINT, 80, 0, 0, 0, 7));
      send_command(make_command(flr_pkg::OP_READ, 0, 24, 0, 0, 0));
      send_command(make_command(flr_pkg::OP_LINE, 0, 0, 79, 23, 8'hAA));
      send_command(make_command(flr_pkg::OP_LINE, 10, 20, 12, 2, 8'h55));
      send_command(make_command(flr_pkg::OP_LINE, 40, 5, 40, 5, 1));
      send_command(make_command(flr_pkg::OP_LINE, 79, 0, 0, 0, 8'h80));
      send_command(make_command(flr_pkg::OP_LINE, 3, 0, 3, 23, 0));
      send_command(make_command(flr_pkg::OP_LINE, 0, 0, 80, 5, 9));
      send_command(make_command(flr_pkg::OP_LINE, -512, -512, 511, 511, 9));
      send_command(make_command(flr_pkg::OP_READ, 40, 5, 0, 0, 0));
   endtask

   task automatic test_canvas_extremes();
      set_canvas(0, 24);
      send_command(make_command(flr_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
      send_command(make_command(flr_pkg::OP_POINT, 0, 0, 0, 0, 3));
      send_command(make_command(flr_pkg::OP_LINE, 0, 0, 1, 1, 3));
      send_command(make_command(flr_pkg::OP_READ, 0, 0, 0, 0, 0));
      // Register values beyond the frame size are held to the frame size.
      set_canvas(511, 255);
      send_command(make_command(flr_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
      send_command(make_command(flr_pkg::OP_READ, 255, 127, 0, 0, 0));
      send_command(make_command(flr_pkg::OP_LINE, 255, 127, 0, 0, 8'hF0));
      send_command(make_command(flr_pkg::OP_READ, 255, 0, 0, 0, 0));
      set_canvas(1, 1);
      send_command(make_command(flr_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
      send_command(make_command(flr_pkg::OP_READ, 0, 0, 0, 0, 0));
   endtask

   task automatic run_random_phase(input int cols, input int rows, input int n_items);
      command_type c;
      int clear_pct;
      set_canvas(cols, rows);
      idling_enabled = ($urandom_range(0, 3) != 0);
      // Software clears before use; random clears stay rare, and are off where the sweep is long.
      send_command(make_command(flr_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
      clear_pct = (canvas_cols() * canvas_rows() <= 4096) ? 3 : 0;
      repeat (n_items) begin
         if ($urandom_range(0, 39) == 0) idling_enabled = !idling_enabled;
         c = random_command(clear_pct);
         send_safe_command(c);
      end
      idling_enabled = 1'b1;
   endtask

   task automatic test_random_phases();
      int phase_cols [12] = '{80, 1, 256, 17, 511, 2, 256, 0, 33, 100, -1, -1};
      int phase_rows [12] = '{24, 1, 128, 9, 255, 128, 1, 10, 0, 60, -1, -1};
      int cols, rows;
      for (int i = 0; i < 12; i++) begin
         cols = (phase_cols[i] < 0) ? $urandom_range(1, 300) : phase_cols[i];
         rows = (phase_rows[i] < 0) ? $urandom_range(1, 140) : phase_rows[i];
         run_random_phase(cols, rows, 110);
      end
   endtask

   // The receiver holds off while items keep coming, so the queue fills and the
   // input stalls behind it.
   task automatic test_output_backpressure();
      set_canvas(64, 32);
      send_command(make_command(flr_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
      wait_results_done();
      idling_enabled   = 1'b0;
      long_hold_cycles = 400;
      repeat (14) send_safe_command(random_command(0));
      idling_enabled = 1'b1;
      wait_results_done();
   endtask

   task automatic test_drained_pause();
      repeat (10) send_safe_command(random_command(2));
      wait_results_done();
      repeat (10) send_safe_command(random_command(2));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_default_canvas();
      test_canvas_extremes();
      test_random_phases();
      test_output_backpressure();
      test_drained_pause();
      wait_results_done();
      repeat (40) @(posedge clock);
      if (predicted_responses.size() != 0)
         report_mismatch($sformatf("%0d response items never arrived",
                                   predicted_responses.size()));
      $display("Sent %0d clears, %0d points, %0d lines and %0d reads over %0d canvas settings.",
               op_count[flr_pkg::OP_CLEAR], op_count[flr_pkg::OP_POINT],
               op_count[flr_pkg::OP_LINE], op_count[flr_pkg::OP_READ], canvas_settings);
      $display("Checked %0d response items, %0d mismatches.", responses_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
